// ===== hdl/r2y420_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// Used by the top level, the line store and the port checker; depends on nothing.

package r2y420_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_DATA_W-1:0] MIN_SIZE           = 12'd2;
    localparam logic [CFG_DATA_W-1:0] ROW_LIMIT          = 12'd2048;

    // Frame counters.
    localparam int COUNT_W = 11;

    // Luma coefficients.
    localparam logic [15:0] Y_R_COEF   = 16'd66;
    localparam logic [15:0] Y_G_COEF   = 16'd129;
    localparam logic [15:0] Y_B_COEF   = 16'd25;
    localparam logic [15:0] Y_ROUND    = 16'd128;
    localparam logic [7:0]  Y_OFFSET   = 8'd16;

    // Chroma coefficients, magnitudes; the sign is applied where they are used.
    localparam logic [15:0] CB_R_COEF  = 16'd38;
    localparam logic [15:0] CB_G_COEF  = 16'd74;
    localparam logic [15:0] CB_B_COEF  = 16'd112;
    localparam logic [15:0] CR_R_COEF  = 16'd112;
    localparam logic [15:0] CR_G_COEF  = 16'd94;
    localparam logic [15:0] CR_B_COEF  = 16'd18;
    // Rounding term plus the 128 offset moved above the shift (128 + 128 * 256).
    localparam logic [15:0] C_BIAS     = 16'd32896;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_end;
    } result_t;

    // Component sums of a horizontal pixel pair.
    typedef struct packed {
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } pair_sum_t;

endpackage

// ===== hdl/r2y420_line_store.sv =====
`timescale 1ns / 1ps
// Line store holding the pair sums of the last even row.
// Single write port, single read port with registered read data; uses r2y420_pkg.

module r2y420_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  r2y420_pkg::pair_sum_t                   wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output r2y420_pkg::pair_sum_t                   rd_data
);

    r2y420_pkg::pair_sum_t mem [DEPTH];
    r2y420_pkg::pair_sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rgb_to_yuv420_converter.sv =====
`timescale 1ns / 1ps
// Top level of the RGB888 to YUV 4:2:0 converter (BT.601 integer form).
// Depends on r2y420_pkg and r2y420_line_store.

// The block takes one pixel per clock in raster order while the result side does not
// stall, and returns one result per pixel. Each result passes three register stages:
// the line store read, the averaging and luma stage, and the chroma stage that feeds
// the output register.
// The sustained rate is one pixel per cycle; stalls on the result side reach the input
// through a combinational ready chain, so the input keeps flowing while any
// stage has room. Pair sums of even rows live in a line store of MAX_WIDTH/2
// entries that is written once per pixel pair on even rows and read once per pair
// on odd rows, so its single port pair never limits the rate. The store needs no
// clearing pass: pixels are accepted right after reset. Configure frame_width and
// frame_height while the block is idle; odd values are rounded down to even.

module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_enable,
    input  logic [r2y420_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [r2y420_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  pixel_valid,
    output logic                                  pixel_stall,
    input  r2y420_pkg::pixel_t                    pixel,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output r2y420_pkg::result_t                   result
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINE_DEPTH - 1);
    localparam logic [13:0] W_MAX = 14'(MAX_WIDTH);
    localparam logic [11:0] W_SAT = 12'((MAX_WIDTH / 2) * 2);
    localparam logic [r2y420_pkg::COUNT_W-1:0] COL_WRAP = '1;

    // Configuration.
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= r2y420_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= r2y420_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                r2y420_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                r2y420_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    logic [11:0] width_even;
    logic [11:0] height_even;
    logic [11:0] width_eff;
    logic [11:0] height_eff;
    logic [11:0] last_col;
    logic [11:0] last_row;

    always_comb
    begin
        width_even  = {frame_width_reg[11:1], 1'b0};
        height_even = {frame_height_reg[11:1], 1'b0};
        if (width_even < r2y420_pkg::MIN_SIZE)
        begin
            width_eff = r2y420_pkg::MIN_SIZE;
        end
        else if ({2'b00, width_even} > W_MAX)
        begin
            width_eff = W_SAT;
        end
        else
        begin
            width_eff = width_even;
        end
        if (height_even < r2y420_pkg::MIN_SIZE)
        begin
            height_eff = r2y420_pkg::MIN_SIZE;
        end
        else if (height_even > r2y420_pkg::ROW_LIMIT)
        begin
            height_eff = r2y420_pkg::ROW_LIMIT;
        end
        else
        begin
            height_eff = height_even;
        end
        last_col = width_eff - 12'd1;
        last_row = height_eff - 12'd1;
    end

    // Pipeline control.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic accept;

    assign out_ready   = !out_valid_reg || !result_stall;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel_stall = !s1_ready;
    assign accept      = pixel_valid && s1_ready;

    // Frame position.
    logic [r2y420_pkg::COUNT_W-1:0] col_reg;
    logic [r2y420_pkg::COUNT_W-1:0] col_next;
    logic [r2y420_pkg::COUNT_W-1:0] row_reg;
    logic [r2y420_pkg::COUNT_W-1:0] row_next;
    logic [IDX_W-1:0]               pidx_reg;
    logic [IDX_W-1:0]               pidx_next;
    r2y420_pkg::pair_sum_t          pair_sum_reg;
    r2y420_pkg::pair_sum_t          pair_sum_next;
    logic                           line_end;
    logic                           frame_last;
    logic                           store_pair;
    logic                           close_block;

    assign line_end    = {1'b0, col_reg} >= last_col;
    assign frame_last  = line_end && ({1'b0, row_reg} >= last_row);
    assign store_pair  = col_reg[0] && !row_reg[0];
    assign close_block = col_reg[0] && row_reg[0];

    always_comb
    begin
        if (!col_reg[0])
        begin
            pair_sum_next.red   = {1'b0, pixel.red};
            pair_sum_next.green = {1'b0, pixel.green};
            pair_sum_next.blue  = {1'b0, pixel.blue};
        end
        else
        begin
            pair_sum_next.red   = pair_sum_reg.red   + {1'b0, pixel.red};
            pair_sum_next.green = pair_sum_reg.green + {1'b0, pixel.green};
            pair_sum_next.blue  = pair_sum_reg.blue  + {1'b0, pixel.blue};
        end

        // The pair index follows col / 2 modulo the store depth without a divider.
        if (line_end)
        begin
            col_next  = '0;
            pidx_next = '0;
            row_next  = frame_last ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
            if (col_reg == COL_WRAP)
            begin
                pidx_next = '0;
            end
            else if (col_reg[0])
            begin
                pidx_next = (pidx_reg == IDX_LAST) ? '0 : pidx_reg + 1'b1;
            end
            else
            begin
                pidx_next = pidx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            pidx_reg     <= '0;
            pair_sum_reg <= '0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pidx_reg     <= pidx_next;
            pair_sum_reg <= pair_sum_next;
        end
    end

    // Even rows write a pair, odd rows read it back a full line later, so a
    // read never meets a pending write to the same entry.
    r2y420_pkg::pair_sum_t above_sum;

    r2y420_line_store #(
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept && store_pair),
        .wr_addr (pidx_reg),
        .wr_data (pair_sum_next),
        .rd_en   (accept && close_block),
        .rd_addr (pidx_reg),
        .rd_data (above_sum)
    );

    // Stage 1: pixel and pair sum wait for the line store read.
    r2y420_pkg::pixel_t    s1_pixel_reg;
    r2y420_pkg::pair_sum_t s1_sum_reg;
    logic                  s1_close_reg;
    logic                  s1_fend_reg;

    // Stage 2: luma and 2x2 averages.
    logic [7:0] s2_luma_reg;
    logic [7:0] s2_avg_r_reg;
    logic [7:0] s2_avg_g_reg;
    logic [7:0] s2_avg_b_reg;
    logic       s2_close_reg;
    logic       s2_fend_reg;

    r2y420_pkg::result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    logic [15:0] y_sum;
    logic [9:0]  quad_r;
    logic [9:0]  quad_g;
    logic [9:0]  quad_b;

    always_comb
    begin
        y_sum = 16'(s1_pixel_reg.red) * r2y420_pkg::Y_R_COEF
              + 16'(s1_pixel_reg.green) * r2y420_pkg::Y_G_COEF
              + 16'(s1_pixel_reg.blue) * r2y420_pkg::Y_B_COEF
              + r2y420_pkg::Y_ROUND;
        quad_r = {1'b0, s1_sum_reg.red}   + {1'b0, above_sum.red};
        quad_g = {1'b0, s1_sum_reg.green} + {1'b0, above_sum.green};
        quad_b = {1'b0, s1_sum_reg.blue}  + {1'b0, above_sum.blue};
    end

    // Both chroma sums stay within 16 bits and above zero for any 8-bit averages.
    logic [15:0] cb_sum;
    logic [15:0] cr_sum;

    always_comb
    begin
        cb_sum = 16'(s2_avg_b_reg) * r2y420_pkg::CB_B_COEF + r2y420_pkg::C_BIAS
               - 16'(s2_avg_r_reg) * r2y420_pkg::CB_R_COEF
               - 16'(s2_avg_g_reg) * r2y420_pkg::CB_G_COEF;
        cr_sum = 16'(s2_avg_r_reg) * r2y420_pkg::CR_R_COEF + r2y420_pkg::C_BIAS
               - 16'(s2_avg_g_reg) * r2y420_pkg::CR_G_COEF
               - 16'(s2_avg_b_reg) * r2y420_pkg::CR_B_COEF;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_sum_reg   <= pair_sum_next;
            s1_close_reg <= close_block;
            s1_fend_reg  <= frame_last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_luma_reg  <= y_sum[15:8] + r2y420_pkg::Y_OFFSET;
            s2_avg_r_reg <= quad_r[9:2];
            s2_avg_g_reg <= quad_g[9:2];
            s2_avg_b_reg <= quad_b[9:2];
            s2_close_reg <= s1_close_reg;
            s2_fend_reg  <= s1_fend_reg;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_reg.luma         <= s2_luma_reg;
            out_reg.chroma_valid <= s2_close_reg;
            out_reg.chroma_blue  <= s2_close_reg ? cb_sum[15:8] : 8'd0;
            out_reg.chroma_red   <= s2_close_reg ? cr_sum[15:8] : 8'd0;
            out_reg.frame_end    <= s2_fend_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hdl/r2y420_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the RGB to YUV 4:2:0 converter, bound to the top level.
// Depends on r2y420_pkg and rgb_to_yuv420_converter.

module r2y420_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               result_valid,
    input logic                               result_stall,
    input r2y420_pkg::result_t                result
);

    logic out_take;
    logic prev_close_reg;

    assign out_take = result_valid && !result_stall;

    // Remembers whether the last delivered result closed a block or a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_close_reg <= 1'b0;
        end
        else if (out_take)
        begin
            prev_close_reg <= result.chroma_valid || result.frame_end;
        end
    end

    // A stalled result request holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.luma >= 8'd16 && result.luma <= 8'd235)
    else $error("luma out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.chroma_valid |->
            result.chroma_blue >= 8'd16 && result.chroma_blue <= 8'd240 &&
            result.chroma_red >= 8'd16 && result.chroma_red <= 8'd240)
    else $error("chroma out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.chroma_valid |->
            result.chroma_blue == 8'd0 && result.chroma_red == 8'd0)
    else $error("chroma not cleared outside a block close");

    // The pixel after a block close starts a new pair, so it cannot close one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && prev_close_reg |-> !result.chroma_valid)
    else $error("two block closes in a row");

endmodule

bind rgb_to_yuv420_converter r2y420_checker u_r2y420_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
);

// ===== tb/yuv420_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the RGB to YUV 4:2:0 converter. It follows register writes and
// accepted pixel requests, predicts every result and compares it with the block's output.
// Depends on r2y420_pkg.

module yuv420_result_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_enable,
    input  logic [r2y420_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [r2y420_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                pixel_valid,
    input  logic                                pixel_stall,
    input  r2y420_pkg::pixel_t                  pixel,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  r2y420_pkg::result_t                 result,
    output int                                  error_count,
    output int                                  pending_count
);

    localparam int SLOTS  = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [r2y420_pkg::CFG_DATA_W-1:0] width_reg;
    logic [r2y420_pkg::CFG_DATA_W-1:0] height_reg;
    int                                column_count;
    int                                row_count;
    r2y420_pkg::pair_sum_t             pair_acc;
    r2y420_pkg::pair_sum_t             line_sums [SLOTS];
    r2y420_pkg::result_t               expected_results [$];
    r2y420_pkg::result_t               oldest;
    int                                mismatch_count = 0;

    assign error_count = mismatch_count;

    function automatic int frame_extent(logic [r2y420_pkg::CFG_DATA_W-1:0] value, int limit);
        int extent;
        extent = int'(value & 12'hFFE);
        if (extent < 2)
        begin
            extent = 2;
        end
        if (extent > limit)
        begin
            extent = limit & ~1;
        end
        return extent;
    endfunction

    // Advances the frame position by one pixel and returns the result it must produce.
    function automatic r2y420_pkg::result_t predict_pixel(r2y420_pkg::pixel_t px);
        int                    line_w;
        int                    rows;
        logic [SLOT_W-1:0]     slot;
        int                    avg_r;
        int                    avg_g;
        int                    avg_b;
        int                    u_sum;
        int                    v_sum;
        r2y420_pkg::pair_sum_t above;
        r2y420_pkg::result_t   res;
        line_w = frame_extent(width_reg, MAX_WIDTH);
        rows   = frame_extent(height_reg, int'(r2y420_pkg::ROW_LIMIT));
        slot   = SLOT_W'((column_count >> 1) % SLOTS);
        res    = '0;
        res.luma = 8'(((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16);
        if (column_count % 2 == 0)
        begin
            pair_acc.red   = 9'(px.red);
            pair_acc.green = 9'(px.green);
            pair_acc.blue  = 9'(px.blue);
        end
        else
        begin
            pair_acc.red   = pair_acc.red + 9'(px.red);
            pair_acc.green = pair_acc.green + 9'(px.green);
            pair_acc.blue  = pair_acc.blue + 9'(px.blue);
            if (row_count % 2 == 0)
            begin
                line_sums[slot] = pair_acc;
            end
            else
            begin
                above = line_sums[slot];
                avg_r = (int'(pair_acc.red) + int'(above.red)) >> 2;
                avg_g = (int'(pair_acc.green) + int'(above.green)) >> 2;
                avg_b = (int'(pair_acc.blue) + int'(above.blue)) >> 2;
                // The +128 chroma offset is folded in above the shift,
                // which keeps both sums positive.
                u_sum = -38 * avg_r - 74 * avg_g + 112 * avg_b + 128 + 32768;
                v_sum = 112 * avg_r - 94 * avg_g - 18 * avg_b + 128 + 32768;
                res.chroma_valid = 1'b1;
                res.chroma_blue  = 8'(u_sum >>> 8);
                res.chroma_red   = 8'(v_sum >>> 8);
            end
        end
        // A shrunken size takes effect at once: any count at or past the last position wraps.
        if (column_count >= line_w - 1)
        begin
            column_count = 0;
            if (row_count >= rows - 1)
            begin
                res.frame_end = 1'b1;
                row_count     = 0;
            end
            else
            begin
                row_count = (row_count + 1) & 11'h7FF;
            end
        end
        else
        begin
            column_count = (column_count + 1) & 11'h7FF;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, r2y420_pkg::result_t want,
                                   r2y420_pkg::result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("checker: %s at %0t: expected Y=%0d cv=%0d U=%0d V=%0d end=%0d,",
                     what, $realtime, want.luma, want.chroma_valid, want.chroma_blue,
                     want.chroma_red, want.frame_end);
            $display("    got Y=%0d cv=%0d U=%0d V=%0d end=%0d",
                     got.luma, got.chroma_valid, got.chroma_blue, got.chroma_red,
                     got.frame_end);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = r2y420_pkg::FRAME_WIDTH_RESET;
            height_reg   = r2y420_pkg::FRAME_HEIGHT_RESET;
            column_count = 0;
            row_count    = 0;
            pair_acc     = '0;
            foreach (line_sums[i])
            begin
                line_sums[i] = '0;
            end
            expected_results.delete();
            pending_count <= 0;
        end
        else
        begin
            // A pixel taken at the same edge as a register write still sees the old size.
            if (pixel_valid && !pixel_stall)
            begin
                expected_results.push_back(predict_pixel(pixel));
            end
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    r2y420_pkg::REG_FRAME_WIDTH:  width_reg  = cfg_data;
                    r2y420_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, result);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.luma !== oldest.luma
                        || result.chroma_valid !== oldest.chroma_valid
                        || result.chroma_blue !== oldest.chroma_blue
                        || result.chroma_red !== oldest.chroma_red
                        || result.frame_end !== oldest.frame_end)
                    begin
                        report_mismatch("wrong result", oldest, result);
                    end
                end
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the RGB to YUV 4:2:0 converter: clock, reset, pixel and register
// stimulus, result-side stalls and the verdict.
// Depends on r2y420_pkg, rgb_to_yuv420_converter and yuv420_result_checker.

module tb;

    localparam int MAX_WIDTH       = 2048;
    localparam int RANDOM_PIXELS   = 850;
    localparam int CALM_TAIL       = 90;
    localparam int HOLD_OFF_CYCLES = 48;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write_enable;
    logic [r2y420_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [r2y420_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                               pixel_valid;
    logic                               pixel_stall;
    r2y420_pkg::pixel_t                 pixel;
    logic                               result_valid;
    logic                               result_stall;
    r2y420_pkg::result_t                result;
    int                                 error_count;
    int                                 pending_count;
    bit                                 bursts_on;
    bit                                 hold_off_wanted;

    rgb_to_yuv420_converter #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result)
    );

    yuv420_result_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) result_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pixel_valid      (pixel_valid),
        .pixel_stall      (pixel_stall),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .result           (result),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Result side: short random stalls, plus one long hold-off once it is requested.
    initial
    begin
        int hold;
        bit hold_off_done;
        hold_off_done = 1'b0;
        result_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_wanted && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                result_stall <= 1'b1;
                for (hold = 0; hold < HOLD_OFF_CYCLES; hold++)
                begin
                    @(posedge clk);
                end
                result_stall <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a clock edge; returns at the edge where the pixel request is taken.
    task automatic offer_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        r2y420_pkg::pixel_t px;
        px.red   = red;
        px.green = green;
        px.blue  = blue;
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [r2y420_pkg::CFG_INDEX_W-1:0] index,
                             logic [r2y420_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= index;
        cfg_data         <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    initial
    begin
        int width_value;
        int height_value;
        int frame_pixels;
        int random_sent;
        bit hold_frame_done;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = r2y420_pkg::REG_FRAME_WIDTH;
        cfg_data         = '0;
        pixel_valid      = 1'b0;
        pixel            = '0;
        bursts_on        = 1'b0;
        hold_off_wanted  = 1'b0;
        random_sent      = 0;
        hold_frame_done  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        bursts_on <= 1'b1;

        // Start row 0 at the reset geometry, then widen to saturation and shrink mid-line.
        offer_pixel(8'h00, 8'h00, 8'h00);
        offer_pixel(8'hFF, 8'hFF, 8'hFF);
        offer_pixel(8'hFF, 8'h00, 8'h00);
        offer_pixel(8'h00, 8'hFF, 8'h00);
        drain();
        write_reg(r2y420_pkg::REG_FRAME_WIDTH, 12'hFFF);
        offer_pixel(8'h00, 8'h00, 8'hFF);
        offer_pixel(8'hFF, 8'hFF, 8'hFF);
        drain();
        // Odd width rounds down to 4, so the next pixel is already past the line end.
        write_reg(r2y420_pkg::REG_FRAME_WIDTH, 12'd5);
        write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 12'd1);
        offer_pixel(8'h80, 8'h80, 8'h80);
        offer_pixel(8'hFF, 8'hFF, 8'hFF);
        offer_pixel(8'h00, 8'h00, 8'h00);
        offer_pixel(8'hFF, 8'h00, 8'hFF);
        offer_pixel(8'h00, 8'hFF, 8'hFF);
        drain();

        // Sizes below the minimum act as 2x2; a pure blue block drives U to its top.
        write_reg(r2y420_pkg::REG_FRAME_WIDTH, 12'd1);
        write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 12'd0);
        repeat (4) offer_pixel(8'h00, 8'h00, 8'hFF);
        drain();

        // Saturated height, then cut it while the frame is on row 3.
        write_reg(r2y420_pkg::REG_FRAME_WIDTH, 12'd3);
        write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 12'hFFF);
        repeat (4) offer_pixel(8'hFF, 8'h00, 8'h00);
        offer_pixel(8'h00, 8'hFF, 8'h00);
        offer_pixel(8'h00, 8'hFF, 8'h00);
        drain();
        write_reg(r2y420_pkg::REG_FRAME_HEIGHT, 12'd2);
        offer_pixel(8'h00, 8'hFF, 8'h00);
        offer_pixel(8'h00, 8'hFF, 8'h00);
        drain();

        width_value  = 3;
        height_value = 2;
        while (random_sent < RANDOM_PIXELS)
        begin
            if (!hold_frame_done && random_sent >= 200)
            begin
                // A long frame, so pixel requests keep coming while results are held off.
                width_value  = 40;
                height_value = 4;
                write_reg(r2y420_pkg::REG_FRAME_WIDTH,
                          r2y420_pkg::CFG_DATA_W'(width_value));
                write_reg(r2y420_pkg::REG_FRAME_HEIGHT,
                          r2y420_pkg::CFG_DATA_W'(height_value));
                hold_off_wanted <= 1'b1;
                hold_frame_done = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    // Wide lines only early on, so the last frame overshoots the count little.
                    width_value = (random_sent < RANDOM_PIXELS / 2
                                   && $urandom_range(0, 9) == 0) ? $urandom_range(18, 64)
                                                                 : $urandom_range(0, 17);
                    write_reg(r2y420_pkg::REG_FRAME_WIDTH,
                              r2y420_pkg::CFG_DATA_W'(width_value));
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    height_value = $urandom_range(0, 9);
                    write_reg(r2y420_pkg::REG_FRAME_HEIGHT,
                              r2y420_pkg::CFG_DATA_W'(height_value));
                end
            end
            bursts_on <= (random_sent < RANDOM_PIXELS - CALM_TAIL)
                         && ($urandom_range(0, 4) != 0);
            frame_pixels = ((width_value < 2) ? 2 : (width_value & ~1))
                         * ((height_value < 2) ? 2 : (height_value & ~1));
            repeat (frame_pixels)
            begin
                if (random_sent >= RANDOM_PIXELS - CALM_TAIL)
                begin
                    bursts_on <= 1'b0;
                end
                offer_pixel(random_level(), random_level(), random_level());
                random_sent++;
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
